// ===== design/virtual_region_allocator_assert.svh =====
// assertion macros for the virtual region allocator
`ifndef VIRTUAL_REGION_ALLOCATOR_ASSERT_SVH
`define VIRTUAL_REGION_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define VRA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define VRA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/vra_pkg.sv =====
// shared constants, codes and types of the virtual region allocator
package vra_pkg;

   localparam int MAX_REGION_COUNT = 64;
   localparam int PAGE_BYTES       = 4096;

   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int IDX_W      = (MAX_REGION_COUNT > 1) ? $clog2(MAX_REGION_COUNT) : 1;
   localparam int CNT_W      = $clog2(MAX_REGION_COUNT + 1);

   localparam int ADDR_W  = 32;
   localparam int PAGES_W = 21;

   localparam logic [ADDR_W-1:0]  BASE_MASK = 32'hffff_f000;
   localparam logic [ADDR_W-1:0]  PAGE_MASK = ADDR_W'(PAGE_BYTES - 1);
   localparam logic [PAGES_W-1:0] PAGES_MAX = {PAGES_W{1'b1}};

   typedef enum logic [1:0] {
      KIND_ALLOC   = 2'd0,
      KIND_RELEASE = 2'd1,
      KIND_CHECK   = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_FULL      = 3'd1,
      STATUS_ZERO      = 3'd2,
      STATUS_NOT_FOUND = 3'd3,
      STATUS_EMPTY     = 3'd4
   } status_type;

   typedef enum logic {
      CSR_POOL_BASE  = 1'b0,
      CSR_POOL_BYTES = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ALLOC_RD,
      ST_SCAN,
      ST_SHIFT
   } state_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  start;
      logic [PAGES_W-1:0] pages;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      entry_type        wdata;
      logic             re;
      logic [IDX_W-1:0] raddr;
   } mem_req_type;

   typedef struct packed {
      logic               valid;
      status_type         status;
      logic [ADDR_W-1:0]  region_start;
      logic [PAGES_W-1:0] pages_to_free;
      logic               is_inside;
   } rsp_type;

endpackage

// ===== design/virtual_region_allocator.sv =====
// Virtual region allocator top level: csr registers, region table ram, sequencer.
// A request is taken when start is high and busy is low; its one result appears
// on the rsp_ ports with rsp_valid high for a single cycle and cannot be held off.
// Check, unused kinds, refused requests and an allocate into an empty table answer
// in the cycle after acceptance; any other allocate first reads the last region
// from the ram and answers from ST_ALLOC_RD. A release reads the table one entry per
// cycle through the single ram read port: it scans from index 0 in ST_SCAN up to a
// match, then moves each later entry down in ST_SHIFT; a miss scans every region.
// busy is low again in the cycle the result is shown, so a new request may follow.
module virtual_region_allocator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_kind,
   input  logic [vra_pkg::ADDR_W-1:0]  req_request_bytes,
   input  logic [vra_pkg::ADDR_W-1:0]  req_target_address,
   output logic                        rsp_valid,
   output logic [2:0]                  rsp_status,
   output logic [vra_pkg::ADDR_W-1:0]  rsp_region_start,
   output logic [vra_pkg::PAGES_W-1:0] rsp_pages_to_free,
   output logic                        rsp_is_inside,
   input  logic                        csr_we,
   input  logic                        csr_index,
   input  logic [vra_pkg::ADDR_W-1:0]  csr_data
);

`include "virtual_region_allocator_assert.svh"

   logic [vra_pkg::ADDR_W-1:0]  pool_base_ff;
   logic [vra_pkg::ADDR_W-1:0]  pool_bytes_ff;
   logic [vra_pkg::ENTRY_W-1:0] rd_data;
   vra_pkg::mem_req_type        mem_req;
   vra_pkg::rsp_type            rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff  <= '0;
         pool_bytes_ff <= '0;
      end else if (csr_we) begin
         unique case (vra_pkg::csr_index_type'(csr_index))
            vra_pkg::CSR_POOL_BASE:  pool_base_ff  <= csr_data;
            vra_pkg::CSR_POOL_BYTES: pool_bytes_ff <= csr_data;
            default:                 pool_base_ff  <= pool_base_ff;
         endcase
      end
   end

   vra_ram #(
      .WIDTH (vra_pkg::ENTRY_W),
      .DEPTH (vra_pkg::MAX_REGION_COUNT)
   ) u_ram (
      .clock (clock),
      .we    (mem_req.we),
      .waddr (mem_req.waddr),
      .wdata (mem_req.wdata),
      .re    (mem_req.re),
      .raddr (mem_req.raddr),
      .rdata (rd_data)
   );

   vra_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .kind           (req_kind),
      .request_bytes  (req_request_bytes),
      .target_address (req_target_address),
      .pool_base      (pool_base_ff),
      .pool_bytes     (pool_bytes_ff),
      .rd_data        (rd_data),
      .mem_req        (mem_req),
      .rsp            (rsp)
   );

   assign rsp_valid         = rsp.valid;
   assign rsp_status        = rsp.status;
   assign rsp_region_start  = rsp.region_start;
   assign rsp_pages_to_free = rsp.pages_to_free;
   assign rsp_is_inside     = rsp.is_inside;

   `VRA_ASSERT_NOW(a_no_rw_overlap, clock, reset, mem_req.we && mem_req.re,
      mem_req.waddr != mem_req.raddr, "ram read and write hit the same entry")
   `VRA_ASSERT_NOW(a_rsp_when_done, clock, reset, rsp_valid, !busy,
      "result shown while a request is still in progress")
   `VRA_ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, rsp_valid || busy,
      "accepted request neither answered nor in progress")

endmodule

// ===== design/vra_ram.sv =====
// generic single-write, single-read ram with registered read data
module vra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                          clock,
   input  logic                                          we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                              wdata,
   input  logic                                          re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                              rdata
);

   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         ram_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= ram_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/vra_ctrl.sv =====
// request sequencer: allocate, release search and compaction, address check
module vra_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  kind,
   input  logic [vra_pkg::ADDR_W-1:0]  request_bytes,
   input  logic [vra_pkg::ADDR_W-1:0]  target_address,
   input  logic [vra_pkg::ADDR_W-1:0]  pool_base,
   input  logic [vra_pkg::ADDR_W-1:0]  pool_bytes,
   input  logic [vra_pkg::ENTRY_W-1:0] rd_data,
   output vra_pkg::mem_req_type        mem_req,
   output vra_pkg::rsp_type            rsp
);

   vra_pkg::state_type state_ff, state_in;
   logic [vra_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [vra_pkg::CNT_W-1:0]   idx_ff, idx_in;
   logic [vra_pkg::ADDR_W-1:0]  addr_ff, addr_in;
   logic [vra_pkg::PAGES_W-1:0] pages_ff, pages_in;
   vra_pkg::rsp_type            rsp_ff, rsp_in;

   vra_pkg::entry_type          rd_entry;
   logic [vra_pkg::ADDR_W-1:0]  base;
   logic [vra_pkg::ADDR_W:0]    pages_wide;
   logic [vra_pkg::PAGES_W-1:0] req_pages;
   logic [vra_pkg::ADDR_W-1:0]  span;
   logic [vra_pkg::ADDR_W-1:0]  next_start;
   logic [vra_pkg::ADDR_W:0]    pool_end;
   logic                        in_pool;
   logic [vra_pkg::CNT_W-1:0]   cnt_dec;
   logic [vra_pkg::CNT_W-1:0]   cnt_inc;
   logic [vra_pkg::CNT_W-1:0]   idx_inc;
   logic [vra_pkg::CNT_W:0]     idx_inc2;
   logic                        accept;
   logic                        req_zero;
   logic                        tbl_full;
   logic                        tbl_empty;
   logic                        scan_hit;
   logic                        scan_last;
   logic                        shift_more;

   assign rd_entry   = vra_pkg::entry_type'(rd_data);
   assign base       = pool_base & vra_pkg::BASE_MASK;
   assign pages_wide = (vra_pkg::ADDR_W + 1)'(request_bytes >> vra_pkg::PAGE_SHIFT)
                     + (vra_pkg::ADDR_W + 1)'(|(request_bytes & vra_pkg::PAGE_MASK));
   assign req_pages  = (pages_wide > (vra_pkg::ADDR_W + 1)'(vra_pkg::PAGES_MAX))
                     ? vra_pkg::PAGES_MAX : pages_wide[vra_pkg::PAGES_W-1:0];
   assign span       = vra_pkg::ADDR_W'(rd_entry.pages) << vra_pkg::PAGE_SHIFT;
   assign next_start = rd_entry.start + span;
   assign pool_end   = {1'b0, base} + {1'b0, pool_bytes};
   assign in_pool    = (target_address >= base) && ({1'b0, target_address} < pool_end);

   assign cnt_dec  = count_ff - vra_pkg::CNT_W'(1);
   assign cnt_inc  = count_ff + vra_pkg::CNT_W'(1);
   assign idx_inc  = idx_ff + vra_pkg::CNT_W'(1);
   assign idx_inc2 = {1'b0, idx_ff} + (vra_pkg::CNT_W + 1)'(2);

   assign accept     = start && (state_ff == vra_pkg::ST_IDLE);
   assign req_zero   = (request_bytes == '0);
   assign tbl_full   = (count_ff == vra_pkg::CNT_W'(vra_pkg::MAX_REGION_COUNT));
   assign tbl_empty  = (count_ff == '0);
   assign scan_hit   = (rd_entry.start == addr_ff);
   assign scan_last  = (idx_inc == count_ff);
   assign shift_more = (idx_inc2 < {1'b0, count_ff});

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         vra_pkg::ST_IDLE: begin
            if (accept) begin
               case (kind)
                  vra_pkg::KIND_ALLOC: begin
                     if (!req_zero && !tbl_full && !tbl_empty) begin
                        state_in = vra_pkg::ST_ALLOC_RD;
                     end
                  end
                  vra_pkg::KIND_RELEASE: begin
                     if (!tbl_empty) begin
                        state_in = vra_pkg::ST_SCAN;
                     end
                  end
                  default: state_in = vra_pkg::ST_IDLE;
               endcase
            end
         end
         vra_pkg::ST_ALLOC_RD: state_in = vra_pkg::ST_IDLE;
         vra_pkg::ST_SCAN: begin
            if (scan_hit) begin
               state_in = scan_last ? vra_pkg::ST_IDLE : vra_pkg::ST_SHIFT;
            end else if (scan_last) begin
               state_in = vra_pkg::ST_IDLE;
            end
         end
         vra_pkg::ST_SHIFT: begin
            if (!shift_more) begin
               state_in = vra_pkg::ST_IDLE;
            end
         end
         default: state_in = vra_pkg::ST_IDLE;
      endcase
   end

   // datapath, memory access and results
   always_comb begin
      count_in = count_ff;
      idx_in   = idx_ff;
      addr_in  = addr_ff;
      pages_in = pages_ff;
      rsp_in   = '0;
      rsp_in.status = vra_pkg::STATUS_OK;
      mem_req  = '0;
      unique case (state_ff)
         vra_pkg::ST_IDLE: begin
            if (accept) begin
               addr_in  = target_address;
               pages_in = req_pages;
               case (kind)
                  vra_pkg::KIND_ALLOC: begin
                     if (req_zero) begin
                        rsp_in.valid  = 1'b1;
                        rsp_in.status = vra_pkg::STATUS_ZERO;
                     end else if (tbl_full) begin
                        rsp_in.valid  = 1'b1;
                        rsp_in.status = vra_pkg::STATUS_FULL;
                     end else if (tbl_empty) begin
                        mem_req.we          = 1'b1;
                        mem_req.waddr       = '0;
                        mem_req.wdata.start = base + vra_pkg::ADDR_W'(vra_pkg::PAGE_BYTES);
                        mem_req.wdata.pages = req_pages;
                        count_in            = cnt_inc;
                        rsp_in.valid        = 1'b1;
                        rsp_in.region_start = base + vra_pkg::ADDR_W'(vra_pkg::PAGE_BYTES);
                     end else begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = cnt_dec[vra_pkg::IDX_W-1:0];
                     end
                  end
                  vra_pkg::KIND_RELEASE: begin
                     if (tbl_empty) begin
                        rsp_in.valid  = 1'b1;
                        rsp_in.status = vra_pkg::STATUS_EMPTY;
                     end else begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = '0;
                        idx_in        = '0;
                     end
                  end
                  vra_pkg::KIND_CHECK: begin
                     rsp_in.valid     = 1'b1;
                     rsp_in.is_inside = in_pool;
                  end
                  default: rsp_in.valid = 1'b1;
               endcase
            end
         end
         vra_pkg::ST_ALLOC_RD: begin
            mem_req.we          = 1'b1;
            mem_req.waddr       = count_ff[vra_pkg::IDX_W-1:0];
            mem_req.wdata.start = next_start;
            mem_req.wdata.pages = pages_ff;
            count_in            = cnt_inc;
            rsp_in.valid        = 1'b1;
            rsp_in.region_start = next_start;
         end
         vra_pkg::ST_SCAN: begin
            if (scan_hit) begin
               pages_in = rd_entry.pages;
               if (scan_last) begin
                  count_in             = cnt_dec;
                  rsp_in.valid         = 1'b1;
                  rsp_in.pages_to_free = rd_entry.pages;
               end else begin
                  mem_req.re    = 1'b1;
                  mem_req.raddr = idx_inc[vra_pkg::IDX_W-1:0];
               end
            end else if (scan_last) begin
               rsp_in.valid  = 1'b1;
               rsp_in.status = vra_pkg::STATUS_NOT_FOUND;
            end else begin
               idx_in        = idx_inc;
               mem_req.re    = 1'b1;
               mem_req.raddr = idx_inc[vra_pkg::IDX_W-1:0];
            end
         end
         vra_pkg::ST_SHIFT: begin
            // entry idx+1 moves down to idx
            mem_req.we    = 1'b1;
            mem_req.waddr = idx_ff[vra_pkg::IDX_W-1:0];
            mem_req.wdata = rd_entry;
            idx_in        = idx_inc;
            if (shift_more) begin
               mem_req.re    = 1'b1;
               mem_req.raddr = idx_inc2[vra_pkg::IDX_W-1:0];
            end else begin
               count_in             = cnt_dec;
               rsp_in.valid         = 1'b1;
               rsp_in.pages_to_free = pages_ff;
            end
         end
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vra_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_ff.valid <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_ff.valid <= rsp_in.valid;
      end
      idx_ff               <= idx_in;
      addr_ff              <= addr_in;
      pages_ff             <= pages_in;
      rsp_ff.status        <= rsp_in.status;
      rsp_ff.region_start  <= rsp_in.region_start;
      rsp_ff.pages_to_free <= rsp_in.pages_to_free;
      rsp_ff.is_inside     <= rsp_in.is_inside;
   end

   assign busy = (state_ff != vra_pkg::ST_IDLE);
   assign rsp  = rsp_ff;

endmodule
